[rtl/core/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg: sequenced reservation ring shared definitions
// Request codes, item structs and default sizes for the ring core.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

	localparam int CAPACITY      = 1024;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int SEQ_W         = 32;

	localparam logic [1:0] REQ_RESERVE = 2'd0;
	localparam logic [1:0] REQ_COMMIT  = 2'd1;
	localparam logic [1:0] REQ_POP     = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [SEQ_W-1:0] commit_sequence;
		logic             commit_valid;
		logic [31:0]      payload_in;
	} req_t;

	typedef struct packed {
		logic             granted;
		logic [SEQ_W-1:0] granted_sequence;
		logic [31:0]      payload_out;
		logic [SEQ_W-1:0] occupancy;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/sequenced_reservation_ring_core.sv]
// ----------------------------------------------------------------------------
// sequenced_reservation_ring_core: sequence-tagged reservation ring
// Reserve / commit / pop against a ring of tagged slots, one result per item.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_data  (srr_pkg::req_t)
// out      out  out_valid / out_ready out_data (srr_pkg::rsp_t)
//
// One item per cycle unless out_ready stalls; results pass s1, s2, s3, out_data.
// s1/s2/s3 resolve the commit slot ((seq-1) mod CAPACITY by reciprocal
// multiply and one correction); s3 executes against counters and slot RAM.
// Pops read a prefetched head slot register with write bypass.
// After reset, the tag RAM is cleared slot by slot; in_ready stays low meanwhile.
// Stages advance independently; bubbles collapse under output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_reservation_ring_core #(
	parameter int CAPACITY      = srr_pkg::CAPACITY,
	parameter int PAYLOAD_WIDTH = srr_pkg::PAYLOAD_WIDTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire srr_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output srr_pkg::rsp_t      out_data
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int REM_W  = SLOT_W + 1;
	localparam int SEQ_W  = srr_pkg::SEQ_W;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

	// pipeline
	logic                v_s1, v_s2, v_s3;
	srr_pkg::req_t       item_s1, item_s2, item_s3;
	logic [SEQ_W-1:0]    x_s2;
	logic [63:0]         prod_s2;
	logic [REM_W-1:0]    rem_s3;
	logic                ld_s1, ld_s2, ld_s3, ld_out, fire_s3;

	logic [SEQ_W-1:0]    x_s1;
	logic [63:0]         prod_d;
	logic [SEQ_W-1:0]    qc;
	logic [REM_W-1:0]    rem_d;
	logic [SLOT_W-1:0]   slot_s3;

	// state
	logic [SEQ_W-1:0]    reserved_q, consumed_q, published_q;
	logic [SEQ_W-1:0]    reserved_d, consumed_d, published_d;
	logic [SLOT_W-1:0]   head_slot_q, head_slot_d;
	logic [SEQ_W-1:0]    head_tag_q;
	logic [PAYLOAD_WIDTH-1:0] head_pay_q;
	logic                clr_active_q;
	logic [SLOT_W-1:0]   clr_cnt_q;

	logic [SEQ_W-1:0]    tag_mem [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] pay_mem [CAPACITY];

	logic                commit_we, pop_ok, tag_we;
	logic [SLOT_W-1:0]   tag_waddr;
	logic [SEQ_W-1:0]    tag_wdata;
	logic [PAYLOAD_WIDTH-1:0] pay_wdata;
	logic [SEQ_W-1:0]    expected, used;
	srr_pkg::rsp_t       rsp_d;
	logic                out_v_q;

	assign ld_out  = !out_v_q || out_ready;
	assign ld_s3   = !v_s3 || ld_out;
	assign ld_s2   = !v_s2 || ld_s3;
	assign ld_s1   = !v_s1 || ld_s2;
	assign in_ready = ld_s1 && !clr_active_q;
	assign fire_s3 = v_s3 && ld_out;

	assign x_s1    = item_s1.commit_sequence - 32'd1;
	assign prod_d  = 64'(x_s1) * 64'(RECIP);
	assign qc      = prod_s2[63:32] * 32'(CAPACITY);
	assign rem_d   = REM_W'(x_s2 - qc);
	assign slot_s3 = (rem_s3 >= REM_W'(CAPACITY)) ? SLOT_W'(rem_s3 - REM_W'(CAPACITY))
	                                              : SLOT_W'(rem_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid && in_ready;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_out) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid && in_ready) item_s1 <= in_data;
		if (ld_s2 && v_s1) begin
			item_s2 <= item_s1;
			x_s2 <= x_s1;
			prod_s2 <= prod_d;
		end
		if (ld_s3 && v_s2) begin
			item_s3 <= item_s2;
			rem_s3 <= rem_d;
		end
		if (fire_s3) out_data <= rsp_d;
	end

	assign out_valid = out_v_q;

	// execute
	always_comb begin
		rsp_d = '0;
		reserved_d = reserved_q;
		consumed_d = consumed_q;
		published_d = published_q;
		commit_we = 1'b0;
		pop_ok = 1'b0;
		expected = consumed_q + 32'd1;
		used = reserved_q - consumed_q;
		if (fire_s3) begin
			case (item_s3.req_type)
				srr_pkg::REQ_RESERVE: begin
					if (used < 32'(CAPACITY)) begin
						reserved_d = reserved_q + 32'd1;
						rsp_d.granted = 1'b1;
						rsp_d.granted_sequence = reserved_q + 32'd1;
					end
				end
				srr_pkg::REQ_COMMIT: begin
					if (item_s3.commit_valid && item_s3.commit_sequence != '0) begin
						commit_we = 1'b1;
						published_d = item_s3.commit_sequence;
					end
				end
				srr_pkg::REQ_POP: begin
					if (published_q >= expected && head_tag_q == expected) begin
						pop_ok = 1'b1;
						consumed_d = expected;
						rsp_d.granted = 1'b1;
						rsp_d.payload_out = 32'(head_pay_q);
					end
				end
				default: ;
			endcase
		end
		rsp_d.occupancy = published_d - consumed_d;
	end

	assign head_slot_d = !pop_ok ? head_slot_q
	                   : (head_slot_q == LAST_SLOT) ? '0 : head_slot_q + SLOT_W'(1);

	assign tag_we    = clr_active_q || commit_we;
	assign tag_waddr = clr_active_q ? clr_cnt_q : slot_s3;
	assign tag_wdata = clr_active_q ? '0 : item_s3.commit_sequence;
	assign pay_wdata = PAYLOAD_WIDTH'(item_s3.payload_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
			consumed_q <= '0;
			published_q <= '0;
			head_slot_q <= '0;
			clr_active_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			reserved_q <= reserved_d;
			consumed_q <= consumed_d;
			published_q <= published_d;
			head_slot_q <= head_slot_d;
			if (clr_active_q) begin
				if (clr_cnt_q == LAST_SLOT) clr_active_q <= 1'b0;
				else clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
		end
	end

	// slot RAMs: head read every cycle at the next head slot, write bypassed
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
		if (tag_we && tag_waddr == head_slot_d) head_tag_q <= tag_wdata;
		else head_tag_q <= tag_mem[head_slot_d];
	end

	always_ff @(posedge clk) begin
		if (commit_we) pay_mem[slot_s3] <= pay_wdata;
		if (commit_we && slot_s3 == head_slot_d) head_pay_q <= pay_wdata;
		else head_pay_q <= pay_mem[head_slot_d];
	end

	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_ready && !v_s1 && !v_s2 && !v_s3)
		else $error("item in flight during tag clear");

	a_pop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok |=> consumed_q == $past(consumed_q) + 32'd1
		           && head_slot_q != $past(head_slot_q))
		else $error("pop did not advance head");

	a_reserve_seq: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s3 && rsp_d.granted && item_s3.req_type == srr_pkg::REQ_RESERVE
		|=> out_data.granted_sequence == reserved_q)
		else $error("granted sequence mismatch");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_slot_q <= LAST_SLOT && clr_cnt_q <= LAST_SLOT)
		else $error("slot index out of range");

endmodule

`default_nettype wire
